@@ design/gscl_pkg.sv @@
// shared types and constants for the glyph slot cache
// used by the controller, the datapath and the top level
package gscl_pkg;

    // table size default and fixed constants
    localparam int          NUM_SLOTS_DEF = 256;
    localparam logic [31:0] AGE_LIMIT     = 32'd99999999;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_PROBE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // configuration register map
    localparam int         CFG_ADDR_W        = 1;
    localparam logic [0:0] ADDR_REPLACE_MODE = 1'b0;

    // read address select
    localparam logic [1:0] RD_HOME   = 2'd0;
    localparam logic [1:0] RD_VICTIM = 2'd1;
    localparam logic [1:0] RD_PROBE  = 2'd2;

    // result select
    localparam logic [1:0] RES_ZERO   = 2'd0;
    localparam logic [1:0] RES_INSERT = 2'd1;
    localparam logic [1:0] RES_PROBE  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       hash_step;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       vic_home;
        logic       scan_start;
        logic       scan_step;
        logic       clr_step;
        logic       cnt_zero;
        logic       commit;
        logic       out_load;
        logic [1:0] res_sel;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic hash_last;
        logic home_valid;
        logic scan_done;
        logic clr_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ design/gscl_datapath.sv @@
// datapath of the glyph slot cache: request registers, hash remainder unit,
// slot memory, scan compare and result register; depends on gscl_pkg
module gscl_datapath
    import gscl_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [31:0] code,
    input  logic [31:0] entry_handle,
    input  logic [7:0]  slot_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  slot,
    output logic        occupied,
    output logic [31:0] stored_code,
    output logic [31:0] stored_handle
);

    localparam int              SLOT_W    = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [SLOT_W:0]   NUM_W1    = (SLOT_W + 1)'(NUM_SLOTS);
    localparam logic [30:0]       NUM_W31   = 31'(NUM_SLOTS);
    // floor of 2^31 / NUM_SLOTS, quotient estimate multiplier
    localparam logic [30:0]       HASH_RECIP = 31'((64'd1 << 31) / NUM_SLOTS);
    localparam logic [1:0]        HASH_LAST  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [31:0] code;
        logic [31:0] handle;
        logic [31:0] age;
    } entry_t;

    // request registers
    logic [31:0] code_reg;
    logic [31:0] handle_reg;
    logic [7:0]  idx_reg;

    // hash remainder unit
    logic [SLOT_W-1:0] rem_reg;
    logic [SLOT_W-1:0] rem_next;
    logic [1:0]        hash_step_reg;
    logic [30:0]       hash_key;
    logic [61:0]       prod_reg;
    logic [30:0]       quot_mul;
    logic [30:0]       rem_diff;
    logic [SLOT_W:0]   rem_raw_reg;

    // slot memory
    entry_t            mem [NUM_SLOTS];
    entry_t            rd_data_reg;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;

    // scan state
    logic [SLOT_W:0]   scan_addr_reg;
    logic              scan_in_range;
    logic [SLOT_W-1:0] eval_addr_reg;
    logic              eval_valid_reg;
    logic [31:0]       least_reg;
    logic [SLOT_W-1:0] vic_reg;
    logic              empty_hit;
    logic              older_hit;

    // counters and result
    logic [31:0]       use_ctr_reg;
    logic              out_valid_reg;
    logic [7:0]        slot_reg;
    logic              occupied_reg;
    logic [31:0]       code_out_reg;
    logic [31:0]       handle_out_reg;
    logic [7:0]        res_slot;
    logic              res_occ;
    logic [31:0]       res_code;
    logic [31:0]       res_handle;
    logic [SLOT_W+7:0] vic_ext;
    logic [SLOT_W+7:0] idx_ext;
    logic              probe_in_range;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg   <= code;
            handle_reg <= entry_handle;
            idx_reg    <= slot_index;
        end
    end

    // remainder by reciprocal multiply in three steps: product, subtract, fix-up
    // the quotient estimate is at most one low, so one compare and subtract ends it
    assign hash_key = code_reg[30:0];
    assign quot_mul = prod_reg[61:31] * NUM_W31;
    assign rem_diff = hash_key - quot_mul;

    always_comb
    begin
        if (rem_raw_reg >= NUM_W1)
            rem_next = SLOT_W'(rem_raw_reg - NUM_W1);
        else
            rem_next = rem_raw_reg[SLOT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= {31'd0, hash_key} * {31'd0, HASH_RECIP};
        rem_raw_reg <= rem_diff[SLOT_W:0];
        if (cmd.load)
            hash_step_reg <= '0;
        else if (cmd.hash_step)
        begin
            hash_step_reg <= hash_step_reg + 2'd1;
            if (hash_step_reg == HASH_LAST)
                rem_reg <= rem_next;
        end
    end

    // probe address range check
    assign idx_ext        = {{SLOT_W{1'b0}}, idx_reg};
    assign probe_in_range = idx_ext < (SLOT_W + 8)'(NUM_SLOTS);

    // read port address select
    assign scan_in_range = scan_addr_reg < NUM_W1;

    always_comb
    begin
        rd_en   = cmd.rd_en || (cmd.scan_step && scan_in_range);
        rd_addr = rem_reg;
        if (cmd.scan_step)
            rd_addr = scan_addr_reg[SLOT_W-1:0];
        else
        begin
            case (cmd.rd_sel)
                RD_HOME:   rd_addr = rem_reg;
                RD_VICTIM: rd_addr = vic_reg;
                RD_PROBE:  rd_addr = idx_ext[SLOT_W-1:0];
                default:   rd_addr = rem_reg;
            endcase
        end
    end

    // write port: clearing pass or new entry
    always_comb
    begin
        wr_en   = cmd.clr_step || cmd.commit;
        wr_addr = vic_reg;
        wr_data = '{valid: 1'b1, code: code_reg, handle: handle_reg, age: use_ctr_reg};
        if (cmd.clr_step)
        begin
            wr_addr = scan_addr_reg[SLOT_W-1:0];
            wr_data = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // scan compare: first empty slot, else first smallest age below the limit
    assign empty_hit = eval_valid_reg && !rd_data_reg.valid;
    assign older_hit = eval_valid_reg && ($signed(rd_data_reg.age) < $signed(least_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.vic_home || cmd.scan_start)
            vic_reg <= rem_reg;
        else if (cmd.scan_step && (empty_hit || older_hit))
            vic_reg <= eval_addr_reg;
        if (cmd.scan_start)
            least_reg <= AGE_LIMIT;
        else if (cmd.scan_step && older_hit)
            least_reg <= rd_data_reg.age;
        if (cmd.scan_step)
            eval_addr_reg <= scan_addr_reg[SLOT_W-1:0];
    end

    // scan and clear address counter, use counter, eval flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg  <= '0;
            eval_valid_reg <= 1'b0;
            use_ctr_reg    <= '0;
        end
        else
        begin
            if (cmd.cnt_zero || cmd.scan_start)
                scan_addr_reg <= '0;
            else if ((cmd.scan_step && scan_in_range) || cmd.clr_step)
                scan_addr_reg <= scan_addr_reg + (SLOT_W + 1)'(1);
            if (cmd.scan_start)
                eval_valid_reg <= 1'b0;
            else if (cmd.scan_step)
                eval_valid_reg <= scan_in_range;
            if (cmd.commit)
                use_ctr_reg <= use_ctr_reg + 32'd1;
        end
    end

    // result select
    assign vic_ext = {8'd0, vic_reg};

    always_comb
    begin
        res_slot   = 8'd0;
        res_occ    = 1'b0;
        res_code   = '0;
        res_handle = '0;
        case (cmd.res_sel)
            RES_INSERT:
            begin
                res_slot = vic_ext[7:0];
                res_occ  = rd_data_reg.valid;
            end
            RES_PROBE:
            begin
                res_slot = idx_reg;
                res_occ  = probe_in_range && rd_data_reg.valid;
            end
            default:
            begin
                res_slot = 8'd0;
                res_occ  = 1'b0;
            end
        endcase
        if (res_occ)
        begin
            res_code   = rd_data_reg.code;
            res_handle = rd_data_reg.handle;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            slot_reg       <= res_slot;
            occupied_reg   <= res_occ;
            code_out_reg   <= res_code;
            handle_out_reg <= res_handle;
        end
    end

    // status back to the controller
    always_comb
    begin
        status.hash_last  = (hash_step_reg == HASH_LAST);
        status.home_valid = rd_data_reg.valid;
        status.scan_done  = empty_hit || (eval_valid_reg && (eval_addr_reg == LAST_SLOT));
        status.clr_last   = (scan_addr_reg == (SLOT_W + 1)'(NUM_SLOTS - 1));
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign slot          = slot_reg;
    assign occupied      = occupied_reg;
    assign stored_code   = code_out_reg;
    assign stored_handle = handle_out_reg;

endmodule

@@ design/gscl_ctrl.sv @@
// controller state machine of the glyph slot cache
// sequences hash, scan, clear and result steps; depends on gscl_pkg
module gscl_ctrl
    import gscl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic        replace_mode,
    input  dp_status_t  status,
    output dp_cmd_t     cmd
);

    localparam logic [3:0] S_INIT       = 4'd0;
    localparam logic [3:0] S_IDLE       = 4'd1;
    localparam logic [3:0] S_HASH       = 4'd2;
    localparam logic [3:0] S_RD_HOME    = 4'd3;
    localparam logic [3:0] S_CHK_HOME   = 4'd4;
    localparam logic [3:0] S_SCAN       = 4'd5;
    localparam logic [3:0] S_RD_VIC     = 4'd6;
    localparam logic [3:0] S_COMMIT     = 4'd7;
    localparam logic [3:0] S_RD_PROBE   = 4'd8;
    localparam logic [3:0] S_PROBE_RESP = 4'd9;
    localparam logic [3:0] S_CLEAR      = 4'd10;
    localparam logic [3:0] S_ZERO_RESP  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel  = RD_HOME;
        cmd.res_sel = RES_ZERO;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (operation)
                        OP_INSERT: state_next = S_HASH;
                        OP_PROBE:  state_next = S_RD_PROBE;
                        OP_CLEAR:
                        begin
                            cmd.cnt_zero = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        default:   state_next = S_ZERO_RESP;
                    endcase
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (status.hash_last)
                    state_next = S_RD_HOME;
            end
            S_RD_HOME:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_HOME;
                state_next = S_CHK_HOME;
            end
            S_CHK_HOME:
            begin
                if (replace_mode && status.home_valid)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cmd.vic_home = 1'b1;
                    state_next   = S_RD_VIC;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                    state_next = S_RD_VIC;
            end
            S_RD_VIC:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_VICTIM;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.res_sel = RES_INSERT;
                if (status.out_free)
                begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RD_PROBE:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PROBE;
                state_next = S_PROBE_RESP;
            end
            S_PROBE_RESP:
            begin
                cmd.res_sel = RES_PROBE;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                    state_next = S_ZERO_RESP;
            end
            S_ZERO_RESP:
            begin
                cmd.res_sel = RES_ZERO;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

@@ design/glyph_slot_cache_lru_unit.sv @@
// glyph slot cache top level: config register, controller and datapath
// insert uses a 3-step hash remainder, plus a slot scan in lru mode;
// one request at a time, the next taken in the cycle after the result is loaded;
// the slot memory read port paces the scan; a stalled result holds the next load
// after reset mode is lru and a clearing pass over every slot runs before in_ready rises
module glyph_slot_cache_lru_unit
    import gscl_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            operation,
    input  logic [31:0]           code,
    input  logic [31:0]           entry_handle,
    input  logic [7:0]            slot_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            slot,
    output logic                  occupied,
    output logic [31:0]           stored_code,
    output logic [31:0]           stored_handle
);

    logic       replace_mode_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            replace_mode_reg <= 1'b1;
        else if (psel && penable && pwrite && (paddr == ADDR_REPLACE_MODE))
            replace_mode_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_REPLACE_MODE)
            prdata = {31'd0, replace_mode_reg};
    end

    // controller
    gscl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .replace_mode (replace_mode_reg),
        .status       (status),
        .cmd          (cmd)
    );

    // datapath
    gscl_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .code          (code),
        .entry_handle  (entry_handle),
        .slot_index    (slot_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .slot          (slot),
        .occupied      (occupied),
        .stored_code   (stored_code),
        .stored_handle (stored_handle)
    );

endmodule

@@ sim/glyph_sb_pkg.sv @@
// scoreboard for the glyph slot cache: slot table predictor and expected result queue
// depends on gscl_pkg for operation codes, table size and the age limit
package glyph_sb_pkg;
    import gscl_pkg::*;

    localparam int         TABLE_SLOTS = NUM_SLOTS_DEF;
    // operation code with no function
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct {
        logic [7:0]  slot;
        logic        occupied;
        logic [31:0] code;
        logic [31:0] handle;
    } glyph_result_t;

    class glyph_scoreboard;
        bit            lru_mode;
        bit            live [TABLE_SLOTS];
        logic [31:0]   codes [TABLE_SLOTS];
        logic [31:0]   handles [TABLE_SLOTS];
        logic [31:0]   ages [TABLE_SLOTS];
        logic [31:0]   use_count;
        glyph_result_t expected_q [$];
        int            errors;

        function new();
            lru_mode  = 1'b1;
            use_count = '0;
            errors    = 0;
            clear_table();
        endfunction

        function void clear_table();
            foreach (live[i])
            begin
                live[i] = 1'b0;
            end
        endfunction

        function void set_mode(bit m);
            lru_mode = m;
        endfunction

        function void flag(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endfunction

        // victim choice: home unless lru and home taken, then first empty or oldest age
        function int unsigned pick_slot(int unsigned home);
            logic [31:0] least;
            int unsigned pick;
            least = AGE_LIMIT;
            pick  = home;
            if (!lru_mode || !live[home])
                return home;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (!live[i])
                    return i;
                if ($signed(ages[i]) < $signed(least))
                begin
                    least = ages[i];
                    pick  = i;
                end
            end
            return pick;
        endfunction

        // update the table for one accepted request and queue its result
        function void note_request(logic [1:0] op, logic [31:0] c, logic [31:0] h,
                                   logic [7:0] idx);
            glyph_result_t r;
            int unsigned   home;
            int unsigned   s;
            r = '{default: '0};
            case (op)
                OP_INSERT:
                begin
                    home = c[30:0] % TABLE_SLOTS;
                    s    = pick_slot(home);
                    if (live[s])
                    begin
                        r.occupied = 1'b1;
                        r.code     = codes[s];
                        r.handle   = handles[s];
                    end
                    live[s]    = 1'b1;
                    codes[s]   = c;
                    handles[s] = h;
                    ages[s]    = use_count;
                    use_count  = use_count + 32'd1;
                    r.slot     = 8'(s);
                end
                OP_PROBE:
                begin
                    r.slot = idx;
                    if (idx < TABLE_SLOTS && live[idx])
                    begin
                        r.occupied = 1'b1;
                        r.code     = codes[idx];
                        r.handle   = handles[idx];
                    end
                end
                OP_CLEAR:
                    clear_table();
                default:
                    ;
            endcase
            expected_q.push_back(r);
        endfunction

        // compare one result with the oldest expectation
        function void check_result(glyph_result_t got);
            glyph_result_t want;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("result with nothing expected: slot %0d", got.slot));
                return;
            end
            want = expected_q.pop_front();
            if (got.slot !== want.slot)
                flag($sformatf("slot %0d, want %0d", got.slot, want.slot));
            if (got.occupied !== want.occupied)
                flag($sformatf("occupied %b, want %b (slot %0d)",
                               got.occupied, want.occupied, want.slot));
            if (got.code !== want.code)
                flag($sformatf("stored_code %h, want %h (slot %0d)",
                               got.code, want.code, want.slot));
            if (got.handle !== want.handle)
                flag($sformatf("stored_handle %h, want %h (slot %0d)",
                               got.handle, want.handle, want.slot));
        endfunction
    endclass

endpackage

@@ sim/tb_top.sv @@
// top-level testbench for glyph_slot_cache_lru_unit: directed and random requests
// in both replacement modes, random stalls on both sides; depends on gscl_pkg and glyph_sb_pkg
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gscl_pkg::*;
    import glyph_sb_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [1:0]            operation     = OP_PROBE;
    logic [31:0]           code          = '0;
    logic [31:0]           entry_handle  = '0;
    logic [7:0]            slot_index    = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic [7:0]            slot;
    logic                  occupied;
    logic [31:0]           stored_code;
    logic [31:0]           stored_handle;

    glyph_scoreboard sb;
    bit              src_idling  = 1'b1;
    bit              sink_idling = 1'b1;
    int unsigned     cycles      = 0;

    glyph_slot_cache_lru_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .code          (code),
        .entry_handle  (entry_handle),
        .slot_index    (slot_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .slot          (slot),
        .occupied      (occupied),
        .stored_code   (stored_code),
        .stored_handle (stored_handle)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        glyph_result_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.slot     = slot;
            seen.occupied = occupied;
            seen.code     = stored_code;
            seen.handle   = stored_handle;
            sb.check_result(seen);
        end
    end

    // result side stalls in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && sink_idling && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 13);
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // config register write, setup then access
    task automatic apb_write(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_REPLACE_MODE;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_mode(value[0]);
        @(posedge clk);
    endtask

    // config register read back
    task automatic apb_check(input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_REPLACE_MODE;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            sb.flag($sformatf("replace_mode reads %h, want %h", got, want));
        @(posedge clk);
    endtask

    // one request: hold until accepted, then maybe leave a gap
    task automatic send_request(input logic [1:0] op, input logic [31:0] c,
                                input logic [31:0] h, input logic [7:0] idx);
        in_valid     <= 1'b1;
        operation    <= op;
        code         <= c;
        entry_handle <= h;
        slot_index   <= idx;
        do @(posedge clk); while (!in_ready);
        sb.note_request(op, c, h, idx);
        if (src_idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // hold off new requests until every expected result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random requests, mostly inserts and probes, rare clears
    task automatic run_random(input int count, input int clear_permille, input int pause_at);
        int unsigned pick;
        logic [1:0]  op;
        logic [31:0] c;
        for (int n = 0; n < count; n++)
        begin
            if (n == pause_at)
                drain();
            pick = $urandom_range(0, 999);
            if (pick < clear_permille)
                op = OP_CLEAR;
            else if (pick < clear_permille + 15)
                op = OP_RESERVED;
            else if (pick < 560)
                op = OP_INSERT;
            else
                op = OP_PROBE;
            // some codes crowd a few home slots
            c = $urandom;
            if ($urandom_range(0, 3) == 0)
                c = c & 32'h8000_0107;
            send_request(op, c, $urandom, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // lru mode: empty table, zero handle, hash ignores bit 31, scan to first empty
        apb_write(32'd1);
        apb_check(32'd1);
        send_request(OP_PROBE, 32'h0, 32'h0, 8'd0);
        send_request(OP_PROBE, 32'hffff_ffff, 32'hffff_ffff, 8'd255);
        send_request(OP_INSERT, 32'h0, 32'h0, 8'd0);
        send_request(OP_PROBE, 32'h0, 32'h0, 8'd0);
        send_request(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
        send_request(OP_INSERT, 32'h8000_0000, 32'h1234_5678, 8'd0);
        send_request(OP_INSERT, 32'h0000_0100, 32'h8765_4321, 8'd0);
        send_request(OP_PROBE, 32'h0, 32'h0, 8'd255);
        send_request(OP_RESERVED, $urandom, $urandom, 8'($urandom_range(0, 255)));
        send_request(OP_PROBE, 32'h0, 32'h0, 8'd1);
        send_request(OP_CLEAR, $urandom, $urandom, 8'($urandom_range(0, 255)));
        send_request(OP_PROBE, 32'h0, 32'h0, 8'd0);
        send_request(OP_INSERT, 32'h5, 32'ha5a5_a5a5, 8'd0);
        drain();

        // direct mode: repeated overwrite of one home slot
        apb_write(32'd0);
        apb_check(32'd0);
        send_request(OP_INSERT, 32'h5, 32'h0, 8'd0);
        send_request(OP_INSERT, 32'h8000_0005, 32'hffff_ffff, 8'd0);
        send_request(OP_INSERT, 32'h0000_0105, 32'h1, 8'd0);
        send_request(OP_PROBE, 32'h0, 32'h0, 8'd5);

        // direct mode random, first stretch without gaps
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        run_random(60, 20, -1);
        src_idling  = 1'b1;
        sink_idling = 1'b1;
        run_random(240, 20, -1);
        drain();

        // lru mode long run so the table fills and evicts oldest entries
        apb_write(32'd1);
        run_random(700, 1, 350);
        drain();

        // direct mode over a full table
        apb_write(32'd0);
        run_random(150, 10, -1);
        drain();

        // closing stretch in lru mode with no stalls
        apb_write(32'd1);
        apb_check(32'd1);
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        run_random(150, 3, -1);
        drain();
        repeat (300) @(posedge clk);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
design/gscl_pkg.sv
design/gscl_datapath.sv
design/gscl_ctrl.sv
design/glyph_slot_cache_lru_unit.sv
sim/glyph_sb_pkg.sv
sim/tb_top.sv
